[rtl/bfcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfcf_pkg;

  // Destination byte address width and the largest store it can reach.
  localparam int IDX_W           = 13;
  localparam int MAX_STORE_BYTES = 2 ** IDX_W;

  localparam int BYTE_W   = 8;
  localparam int PHASE_W  = 3;
  localparam int LEN_W    = 17;
  localparam int DSTART_W = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_FILL_MODE  = 3'd0;
  localparam logic [2:0] REG_FILL_BIT   = 3'd1;
  localparam logic [2:0] REG_SRC_START  = 3'd2;
  localparam logic [2:0] REG_DST_START  = 3'd3;
  localparam logic [2:0] REG_RUN_LENGTH = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = LEN_W;

  // Result queue depth; a transaction may push two entries.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic [IDX_W-1:0]  dest_index;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] write_mask;
    logic              run_done;
  } wr_t;

  typedef struct packed {
    logic v0;
    logic v1;
    wr_t  w0;
    wr_t  w1;
  } push_t;

endpackage

`default_nettype wire

[rtl/bit_field_copy_fill.sv]
`timescale 1ns / 1ps
`default_nettype none

// Unaligned bit-field copy and fill engine. Each stream transaction on the
// slave side carries one source byte; a run begins with the transaction whose
// tuser bit is set, using the configuration registers as they stand then
// (write them only while the block is idle). Bits are numbered LSB first and
// are placed at any bit offset of the destination store; every destination
// byte leaves as one masked write (index, data, mask) on the master side, and
// tlast marks the final write of the run. The run is clipped to the store of
// min(DEST_BYTES, 8192) bytes. The block takes one source byte per clock
// while tready is high: the step logic sits between the input handshake and
// a four-entry result queue. A source byte yields zero, one or two writes;
// two appear only when the last byte of a run both closes a destination
// byte and flushes the carry, and the queue absorbs the extra write. tready
// drops only when the queue holds more than two writes.
module bit_field_copy_fill #(
  parameter int DEST_BYTES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  // Source stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  wire logic        s_axis_tuser,   // [0] run_start
  // Destination write stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [12:0] dest_index, [20:13] write_data,
                                           // [28:21] write_mask, [31:29] zero
  output logic             m_axis_tlast    // run_done
);

  localparam int STORE_BYTES = (DEST_BYTES < bfcf_pkg::MAX_STORE_BYTES) ?
                               DEST_BYTES : bfcf_pkg::MAX_STORE_BYTES;
  localparam logic [bfcf_pkg::LEN_W-1:0] STORE_BITS = bfcf_pkg::LEN_W'(STORE_BYTES * 8);

  // Configuration registers
  logic                             fill_mode;
  logic                             fill_bit;
  logic [bfcf_pkg::PHASE_W-1:0]     src_start;
  logic [bfcf_pkg::DSTART_W-1:0]    dst_start;
  logic [bfcf_pkg::LEN_W-1:0]       run_length;
  logic [bfcf_pkg::LEN_W-1:0]       run_length_clip;  // run length cut to the store

  // Run state
  logic [bfcf_pkg::BYTE_W-1:0]      carry_bits;
  logic [bfcf_pkg::BYTE_W-1:0]      carry_mask;
  logic [bfcf_pkg::PHASE_W-1:0]     dest_phase;
  logic [bfcf_pkg::LEN_W-1:0]       bits_left;
  logic [bfcf_pkg::IDX_W-1:0]       next_dest_index;
  logic                             first_byte_pending;

  logic [bfcf_pkg::BYTE_W-1:0]      carry_bits_next;
  logic [bfcf_pkg::BYTE_W-1:0]      carry_mask_next;
  logic [bfcf_pkg::PHASE_W-1:0]     dest_phase_next;
  logic [bfcf_pkg::LEN_W-1:0]       bits_left_next;
  logic [bfcf_pkg::IDX_W-1:0]       next_dest_index_next;
  logic                             first_byte_pending_next;

  logic                             in_acc;
  logic                             q_ready;
  bfcf_pkg::push_t                  push;
  bfcf_pkg::wr_t                    q_entry;

  // Clip a run to the store: empty when the start lies past the end.
  function automatic logic [bfcf_pkg::LEN_W-1:0] clip_len(
    input logic [bfcf_pkg::DSTART_W-1:0] dst,
    input logic [bfcf_pkg::LEN_W-1:0]    len
  );
    logic [bfcf_pkg::LEN_W-1:0] dst_w;
    logic [bfcf_pkg::LEN_W-1:0] room;
    dst_w = bfcf_pkg::LEN_W'(dst);
    room  = STORE_BITS - dst_w;
    if (dst_w >= STORE_BITS) begin
      return '0;
    end else if (len < room) begin
      return len;
    end else begin
      return room;
    end
  endfunction

  // Configuration writes; refresh the clipped length with the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode       <= 1'b0;
      fill_bit        <= 1'b0;
      src_start       <= '0;
      dst_start       <= '0;
      run_length      <= '0;
      run_length_clip <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfcf_pkg::REG_FILL_MODE: begin
          fill_mode <= cfg_data[0];
        end
        bfcf_pkg::REG_FILL_BIT: begin
          fill_bit <= cfg_data[0];
        end
        bfcf_pkg::REG_SRC_START: begin
          src_start <= cfg_data[bfcf_pkg::PHASE_W-1:0];
        end
        bfcf_pkg::REG_DST_START: begin
          dst_start       <= cfg_data[bfcf_pkg::DSTART_W-1:0];
          run_length_clip <= clip_len(cfg_data[bfcf_pkg::DSTART_W-1:0], run_length);
        end
        bfcf_pkg::REG_RUN_LENGTH: begin
          run_length      <= cfg_data;
          run_length_clip <= clip_len(dst_start, cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = q_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Single-pass step for one source byte.
  always_comb begin
    logic [bfcf_pkg::BYTE_W-1:0]  r_carry;
    logic [bfcf_pkg::BYTE_W-1:0]  r_cmask;
    logic [bfcf_pkg::PHASE_W-1:0] r_phase;
    logic [bfcf_pkg::LEN_W-1:0]   r_left;
    logic [bfcf_pkg::IDX_W-1:0]   r_idx;
    logic                         r_first;
    logic [bfcf_pkg::BYTE_W-1:0]  sb;
    logic [bfcf_pkg::PHASE_W-1:0] shift;
    logic [3:0]                   avail;
    logic [3:0]                   n;
    logic [bfcf_pkg::BYTE_W-1:0]  nmask;
    logic [bfcf_pkg::BYTE_W-1:0]  bits;
    logic [15:0]                  acc;
    logic [15:0]                  accmask;
    logic [3:0]                   total;
    logic [bfcf_pkg::LEN_W-1:0]   left_after;
    logic                         active;
    logic                         first_v;
    logic                         flush_v;
    bfcf_pkg::wr_t                first_w;
    bfcf_pkg::wr_t                flush_w;

    // Start of run: reload from configuration, drop any unwritten carry.
    if (s_axis_tuser) begin
      r_carry = '0;
      r_cmask = '0;
      r_phase = dst_start[bfcf_pkg::PHASE_W-1:0];
      r_left  = run_length_clip;
      r_idx   = dst_start[bfcf_pkg::DSTART_W-1:bfcf_pkg::PHASE_W];
      r_first = 1'b1;
    end else begin
      r_carry = carry_bits;
      r_cmask = carry_mask;
      r_phase = dest_phase;
      r_left  = bits_left;
      r_idx   = next_dest_index;
      r_first = first_byte_pending;
    end

    active = (r_left != '0);

    if (fill_mode) begin
      shift = '0;
      avail = 4'd8 - 4'(r_phase);
      sb    = fill_bit ? 8'hff : 8'h00;
    end else begin
      shift = r_first ? src_start : '0;
      avail = 4'd8 - 4'(shift);
      sb    = s_axis_tdata;
    end

    n          = (bfcf_pkg::LEN_W'(avail) < r_left) ? avail : r_left[3:0];
    nmask      = 8'((9'd1 << n) - 9'd1);
    bits       = (sb >> shift) & nmask;
    left_after = r_left - bfcf_pkg::LEN_W'(n);
    acc        = 16'(r_carry) | (16'(bits) << r_phase);
    accmask    = 16'(r_cmask) | (16'(nmask) << r_phase);
    total      = 4'(r_phase) + n;

    first_v            = active && total[3];
    first_w.dest_index = r_idx;
    first_w.write_data = acc[7:0] & accmask[7:0];
    first_w.write_mask = accmask[7:0];
    first_w.run_done   = (left_after == '0) && (accmask[15:8] == '0);

    carry_bits_next         = r_carry;
    carry_mask_next         = r_cmask;
    dest_phase_next         = r_phase;
    bits_left_next          = r_left;
    next_dest_index_next    = r_idx;
    first_byte_pending_next = r_first;

    if (active) begin
      first_byte_pending_next = 1'b0;
      bits_left_next          = left_after;
      if (total[3]) begin
        // Byte complete: advance the index, keep the spill bits.
        next_dest_index_next = r_idx + 1'b1;
        carry_bits_next      = acc[15:8];
        carry_mask_next      = accmask[15:8];
        dest_phase_next      = total[2:0];
      end else begin
        carry_bits_next = acc[7:0];
        carry_mask_next = accmask[7:0];
        dest_phase_next = total[2:0];
      end
    end

    // End of run with a partial byte in the carry: flush it.
    flush_v            = active && (left_after == '0) && (carry_mask_next != '0);
    flush_w.dest_index = next_dest_index_next;
    flush_w.write_data = carry_bits_next & carry_mask_next;
    flush_w.write_mask = carry_mask_next;
    flush_w.run_done   = 1'b1;
    if (flush_v) begin
      carry_bits_next = '0;
      carry_mask_next = '0;
    end

    push.v0 = in_acc && (first_v || flush_v);
    push.v1 = in_acc && first_v && flush_v;
    push.w0 = first_v ? first_w : flush_w;
    push.w1 = flush_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bits         <= '0;
      carry_mask         <= '0;
      dest_phase         <= '0;
      bits_left          <= '0;
      next_dest_index    <= '0;
      first_byte_pending <= 1'b1;
    end else if (in_acc) begin
      carry_bits         <= carry_bits_next;
      carry_mask         <= carry_mask_next;
      dest_phase         <= dest_phase_next;
      bits_left          <= bits_left_next;
      next_dest_index    <= next_dest_index_next;
      first_byte_pending <= first_byte_pending_next;
    end
  end

  bfcf_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (q_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_entry  (q_entry)
  );

  assign m_axis_tdata = {3'b000, q_entry.write_mask, q_entry.write_data, q_entry.dest_index};
  assign m_axis_tlast = q_entry.run_done;

  // Carry bits always sit below the destination bit phase.
  a_carry_below_phase : assert property (@(posedge clk) disable iff (rst)
    (carry_mask >> dest_phase) == '0)
    else $error("carry mask reaches past the destination phase");

  // Every write replaces at least one bit, and data stays inside its mask.
  a_mask_nonzero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (q_entry.write_mask != '0))
    else $error("write with an empty mask");

  a_data_in_mask : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((q_entry.write_data & ~q_entry.write_mask) == '0))
    else $error("write data outside its mask");

  // With no bits left, nothing waits in the carry.
  a_idle_no_carry : assert property (@(posedge clk) disable iff (rst)
    (bits_left == '0) |-> (carry_mask == '0))
    else $error("carry left over after the run ended");

endmodule

`default_nettype wire

[rtl/bfcf_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfcf_out_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bfcf_pkg::push_t push,
  output logic                push_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bfcf_pkg::wr_t       out_entry
);

  bfcf_pkg::wr_t                  entries [bfcf_pkg::QDEPTH];
  logic [bfcf_pkg::QPTR_W-1:0]    head;
  logic [bfcf_pkg::QPTR_W-1:0]    tail;
  logic [bfcf_pkg::QCNT_W-1:0]    count;
  logic [bfcf_pkg::QCNT_W-1:0]    count_next;
  logic [bfcf_pkg::QCNT_W-1:0]    n_push;
  logic                           pop;

  assign pop        = out_valid && out_ready;
  assign n_push     = bfcf_pkg::QCNT_W'(push.v0) + bfcf_pkg::QCNT_W'(push.v1);
  assign count_next = count + n_push - bfcf_pkg::QCNT_W'(pop);

  // Room for two entries whatever the output side does this cycle.
  assign push_ready = (count <= bfcf_pkg::QCNT_W'(bfcf_pkg::QDEPTH - 2));
  assign out_valid  = (count != '0);
  assign out_entry  = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      tail  <= tail + n_push[bfcf_pkg::QPTR_W-1:0];
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[tail] <= push.w0;
    end
    if (push.v1) begin
      entries[tail + 1'b1] <= push.w1;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    count <= bfcf_pkg::QCNT_W'(bfcf_pkg::QDEPTH))
    else $error("result queue overflow");

  a_pop_decrements : assert property (@(posedge clk) disable iff (rst)
    (pop && !push.v0 && !push.v1) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");

  a_second_needs_first : assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second entry pushed without the first");

endmodule

`default_nettype wire
